### rtl/sgml_entity_decoder_assert.svh
// Assertion macros used by the entity decoder top level.
`ifndef SGML_ENTITY_DECODER_ASSERT_SVH
`define SGML_ENTITY_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define SED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SED_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SED_ASSERT(lbl, prop, msg)
`define SED_NEVER(lbl, cond, msg)
`endif
`endif

### rtl/sed_pkg.sv
// Constants, types and the name table of the entity decoder.
package sed_pkg;
  localparam int NAME_LIMIT    = 10;
  localparam int NAME_MAX      = NAME_LIMIT - 1;
  localparam int TABLE_ENTRIES = 100;
  localparam int LEN_W         = $clog2(NAME_LIMIT);
  localparam int IDX_W         = $clog2(NAME_MAX);
  localparam int STR_W         = 8 * NAME_MAX;
  localparam int FIFO_DEPTH    = 4;
  localparam int PTR_W         = $clog2(FIFO_DEPTH);
  localparam int CNT_W         = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;

  typedef logic [6:0] nchar_t;
  typedef nchar_t name_t [NAME_MAX];
  typedef logic [TABLE_ENTRIES-1:0] cand_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } res_t;

  typedef enum logic [1:0] {
    ST_RUN    = 2'b01,
    ST_REPLAY = 2'b10
  } state_t;

  localparam logic [STR_W-1:0] ROM_STR [TABLE_ENTRIES] = '{
    "lt", "gt", "amp", "quot", "nbsp", "iexcl", "cent", "pound",
    "curren", "yen", "brvbar", "sect", "uml", "copy", "ordf", "laquo",
    "not", "shy", "reg", "hibar", "deg", "plusmn", "sup2", "sup3",
    "acute", "micro", "para", "middot", "cedil", "sup1", "ordm", "raquo",
    "frac14", "frac12", "frac34", "iquest", "Agrave", "Aacute", "Acirc", "Atilde",
    "Aring", "Auml", "AElig", "Ccedil", "Egrave", "Eacute", "Ecirc", "Euml",
    "Igrave", "Iacute", "Icirc", "Iuml", "ETH", "Ntilde", "Ograve", "Oacute",
    "Ocirc", "Otilde", "Ouml", "times", "Oslash", "Ugrave", "Uacute", "Ucirc",
    "Uuml", "Yacute", "THORN", "szlig", "agrave", "aacute", "acirc", "atilde",
    "auml", "aring", "aelig", "ccedil", "egrave", "eacute", "ecirc", "euml",
    "igrave", "iacute", "icirc", "iuml", "eth", "ntilde", "ograve", "oacute",
    "ocirc", "otilde", "ouml", "divide", "oslash", "ugrave", "uacute", "ucirc",
    "uuml", "yacute", "thorn", "yuml"
  };

  // Codes run from 160 upwards after the four markup characters.
  function automatic logic [7:0] rom_code(int i);
    logic [7:0] c;
    case (i)
      0: c = 8'd60;
      1: c = 8'd62;
      2: c = 8'd38;
      3: c = 8'd34;
      default: c = 8'(156 + i);
    endcase
    return c;
  endfunction

  function automatic logic [LEN_W-1:0] rom_len(int i);
    int n;
    n = 0;
    for (int k = 0; k < NAME_MAX; k++) begin
      if (ROM_STR[i][8*k +: 8] != 8'h00) n = k + 1;
    end
    return LEN_W'(n);
  endfunction

  // Left-aligned characters; positions past the end hold zero.
  function automatic name_t rom_name(int i);
    name_t r;
    int n;
    n = int'(rom_len(i));
    for (int k = 0; k < NAME_MAX; k++) begin
      if (k < n) r[k] = ROM_STR[i][8*(n-1-k) +: 7];
      else r[k] = '0;
    end
    return r;
  endfunction
endpackage

### rtl/sgml_entity_decoder.sv
// Top level of the streaming named-entity decoder.
// Results pass through a registered result queue.
// Throughput: one input byte per cycle while the queue has room for two,
// except during replay: an overlong name blocks input while the stored name is
// read back from name memory, one character per cycle while the queue has room.
// Reset (rst_n low, synchronous) leaves the entity and empties the result queue.
module sgml_entity_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last
);
  import sed_pkg::*;

  `include "sgml_entity_decoder_assert.svh"

  // Entity tracking. The candidate vector holds one bit per table name that
  // still agrees with every character collected so far.
  state_t            state_r, state_nxt;
  logic              inside_r, inside_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  cand_t             cand_r, cand_nxt, cand_upd, lk_cand;
  logic [LEN_W-1:0]  lk_len;
  logic [7:0]        code;

  // Name memory, used only to replay an overlong name literally.
  nchar_t            name_mem [NAME_MAX];
  logic [LEN_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              rd_valid_r;
  nchar_t            rd_data_r;
  logic              rd_issue;
  logic [7:0]        tail_byte_r;

  // Result queue.
  res_t              fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  head_r, tail_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [1:0]        push_n;
  res_t              push0, push1;
  logic              pop;

  logic              acc, is_name, store, abort_hit, close;
  logic [7:0]        b;
  logic              eot;

  assign b   = in_text_byte;
  assign eot = in_end_of_text;

  assign in_ready = (state_r == ST_RUN) && (cnt_r <= CNT_W'(FIFO_DEPTH - 2));
  assign acc      = in_valid && in_ready;

  assign is_name = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A)) ||
                   (b == CH_DOT) || (b == CH_DASH);
  assign store     = inside_r && is_name && (len_r < LEN_W'(NAME_MAX));
  assign abort_hit = inside_r && is_name && !store;
  assign close     = inside_r && !is_name;

  // Narrow the candidates by the new character at the current position.
  always_comb begin
    name_t nm;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      nm          = rom_name(i);
      cand_upd[i] = cand_r[i] && (nm[len_r[IDX_W-1:0]] == b[6:0]);
    end
  end

  // One lookup serves both a close and a flush straight after a new character;
  // the two never happen on the same byte.
  assign lk_cand = store ? cand_upd : cand_r;
  assign lk_len  = store ? (len_r + LEN_W'(1)) : len_r;

  sed_lookup u_lookup (
    .cand (lk_cand),
    .len  (lk_len),
    .code (code)
  );

  // Issue a read only when the queue is sure to have room next cycle.
  assign rd_issue = (state_r == ST_REPLAY) && (rd_idx_r < LEN_W'(NAME_MAX)) &&
                    (({1'b0, cnt_r} + {{CNT_W{1'b0}}, rd_valid_r}) <
                     (CNT_W+1)'(FIFO_DEPTH));

  always_comb begin
    state_nxt  = state_r;
    inside_nxt = inside_r;
    len_nxt    = len_r;
    cand_nxt   = cand_r;
    rd_idx_nxt = rd_idx_r;
    push_n     = 2'd0;
    push0      = '{data: CH_SPACE, last: 1'b1};
    push1      = '{data: CH_SPACE, last: 1'b1};
    case (state_r)
      ST_RUN: begin
        if (acc) begin
          if (!inside_r) begin
            if (b == CH_AMP) begin
              inside_nxt = !eot;
              len_nxt    = '0;
              cand_nxt   = '1;
              if (eot) push_n = 2'd1;
            end else begin
              push_n = 2'd1;
              push0  = '{data: b, last: 1'b1};
            end
          end else if (store) begin
            if (eot) begin
              push_n     = 2'd1;
              push0      = '{data: code, last: 1'b1};
              inside_nxt = 1'b0;
              len_nxt    = '0;
            end else begin
              len_nxt  = len_r + LEN_W'(1);
              cand_nxt = cand_upd;
            end
          end else if (abort_hit) begin
            // The ampersand goes out now, the stored name and this byte follow.
            push_n     = 2'd1;
            push0      = '{data: CH_AMP, last: 1'b0};
            inside_nxt = 1'b0;
            len_nxt    = '0;
            state_nxt  = ST_REPLAY;
            rd_idx_nxt = '0;
          end else if (close) begin
            inside_nxt = 1'b0;
            len_nxt    = '0;
            if (b == CH_SEMI) begin
              push_n = 2'd1;
              push0  = '{data: code, last: 1'b1};
            end else if (b == CH_AMP) begin
              if (eot) begin
                push_n = 2'd2;
                push0  = '{data: code, last: 1'b0};
              end else begin
                push_n     = 2'd1;
                push0      = '{data: code, last: 1'b1};
                inside_nxt = 1'b1;
                cand_nxt   = '1;
              end
            end else begin
              push_n = 2'd2;
              push0  = '{data: code, last: 1'b0};
              push1  = '{data: b, last: 1'b1};
            end
          end
        end
      end
      ST_REPLAY: begin
        if (rd_valid_r) begin
          push_n = 2'd1;
          push0  = '{data: {1'b0, rd_data_r}, last: 1'b0};
        end else if ((rd_idx_r == LEN_W'(NAME_MAX)) && (cnt_r < CNT_W'(FIFO_DEPTH))) begin
          push_n    = 2'd1;
          push0     = '{data: tail_byte_r, last: 1'b1};
          state_nxt = ST_RUN;
        end
        if (rd_issue) rd_idx_nxt = rd_idx_r + LEN_W'(1);
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_RUN;
      inside_r   <= 1'b0;
      len_r      <= '0;
      rd_idx_r   <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      inside_r   <= inside_nxt;
      len_r      <= len_nxt;
      rd_idx_r   <= rd_idx_nxt;
      rd_valid_r <= rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
    if (acc && abort_hit) tail_byte_r <= b;
  end

  // Name memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (acc && store) name_mem[len_r[IDX_W-1:0]] <= b[6:0];
    if (rd_issue) rd_data_r <= name_mem[rd_idx_r[IDX_W-1:0]];
  end

  // Result queue.
  assign pop          = out_valid && out_ready;
  assign out_valid    = (cnt_r != '0);
  assign out_byte     = fifo_r[head_r].data;
  assign out_run_last = fifo_r[head_r].last;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) fifo_r[tail_r] <= push0;
    if (push_n == 2'd2) fifo_r[tail_r + PTR_W'(1)] <= push1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (pop) head_r <= head_r + PTR_W'(1);
      tail_r <= tail_r + PTR_W'(push_n);
      cnt_r  <= cnt_r + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

  `SED_NEVER(a_fifo_overflow, cnt_r > CNT_W'(FIFO_DEPTH), "result queue overflow")
  `SED_ASSERT(a_replay_blocks, (state_r == ST_REPLAY) |-> !in_ready, "input taken in replay")
  `SED_NEVER(a_len_range, len_r > LEN_W'(NAME_MAX), "name length out of range")
  `SED_ASSERT(a_abort_replay, (acc && abort_hit) |=> (state_r == ST_REPLAY), "no replay")
endmodule

### rtl/sed_lookup.sv
// Resolves the surviving candidate set and name length to one output code.
module sed_lookup (
  input  sed_pkg::cand_t           cand,
  input  logic [sed_pkg::LEN_W-1:0] len,
  output logic [7:0]                code
);
  import sed_pkg::*;

  logic       hit_any;
  logic [7:0] code_or;

  // Names are unique, so at most one entry can survive with a matching length.
  always_comb begin
    hit_any = 1'b0;
    code_or = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (cand[i] && (rom_len(i) == len)) begin
        hit_any = 1'b1;
        code_or = code_or | rom_code(i);
      end
    end
    code = hit_any ? code_or : CH_SPACE;
  end
endmodule

### tb/tb_sgml_entity_decoder.sv
// Self-checking testbench for the streaming named-entity decoder.
module tb_sgml_entity_decoder;
  import sed_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       eot;
    logic       has_want;  // a result is typed in below
    logic [7:0] want;      // single result expected for this transaction
  } stim_row_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } decoded_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 130;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_text_byte;
  logic       in_end_of_text;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_run_last;

  sgml_entity_decoder DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_text_byte(in_text_byte), .in_end_of_text(in_end_of_text),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte(out_byte), .out_run_last(out_run_last)
  );

  // The predictor's own view of the decoder state.
  logic       in_name;
  int         name_len;
  logic [6:0] name_buf [NAME_LIMIT];

  // Results still owed by the decoder, oldest first.
  decoded_t   owed_q[$];
  int         mismatches;
  int         idle_cycles;
  logic       calm;        // when set, neither side idles
  logic       timed_out;

  // The decoding table, written out by hand so that it is independent of the
  // package functions; note that Igrave and Iacute carry 204 and 205.
  string      ent_names [TABLE_ENTRIES] = '{
    "lt", "gt", "amp", "quot", "nbsp", "iexcl", "cent", "pound",
    "curren", "yen", "brvbar", "sect", "uml", "copy", "ordf", "laquo",
    "not", "shy", "reg", "hibar", "deg", "plusmn", "sup2", "sup3",
    "acute", "micro", "para", "middot", "cedil", "sup1", "ordm", "raquo",
    "frac14", "frac12", "frac34", "iquest", "Agrave", "Aacute", "Acirc", "Atilde",
    "Aring", "Auml", "AElig", "Ccedil", "Egrave", "Eacute", "Ecirc", "Euml",
    "Igrave", "Iacute", "Icirc", "Iuml", "ETH", "Ntilde", "Ograve", "Oacute",
    "Ocirc", "Otilde", "Ouml", "times", "Oslash", "Ugrave", "Uacute", "Ucirc",
    "Uuml", "Yacute", "THORN", "szlig", "agrave", "aacute", "acirc", "atilde",
    "auml", "aring", "aelig", "ccedil", "egrave", "eacute", "ecirc", "euml",
    "igrave", "iacute", "icirc", "iuml", "eth", "ntilde", "ograve", "oacute",
    "ocirc", "otilde", "ouml", "divide", "oslash", "ugrave", "uacute", "ucirc",
    "uuml", "yacute", "thorn", "yuml"
  };
  logic [7:0] ent_codes [TABLE_ENTRIES];

  initial begin
    ent_codes[0] = 8'd60;
    ent_codes[1] = 8'd62;
    ent_codes[2] = 8'd38;
    ent_codes[3] = 8'd34;
    for (int i = 4; i < TABLE_ENTRIES; i++) ent_codes[i] = 8'(156 + i);
  end

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic is_name_byte(logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
           b == CH_DOT || b == CH_DASH;
  endfunction

  // Looks up the collected name; an empty or unknown name decodes to a space.
  function automatic logic [7:0] decode_name();
    logic hit;
    if (name_len == 0) return CH_SPACE;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (ent_names[i].len() == name_len) begin
        hit = 1'b1;
        for (int k = 0; k < name_len; k++)
          if (ent_names[i][k] != {1'b0, name_buf[k]}) hit = 1'b0;
        if (hit) return ent_codes[i];
      end
    end
    return CH_SPACE;
  endfunction

  // Advances the predictor by one byte and returns the bytes it decodes to.
  function automatic void decode_byte(logic [7:0] b, logic eot,
                                      ref logic [7:0] res[$]);
    res = {};
    if (!in_name) begin
      if (b == CH_AMP) begin
        in_name  = 1'b1;
        name_len = 0;
      end else begin
        res.push_back(b);
      end
    end else if (is_name_byte(b)) begin
      if (name_len + 1 < NAME_LIMIT) begin
        name_buf[name_len] = b[6:0];
        name_len++;
      end else begin
        // An overlong name is given back literally.
        res.push_back(CH_AMP);
        for (int k = 0; k < name_len; k++) res.push_back({1'b0, name_buf[k]});
        res.push_back(b);
        in_name  = 1'b0;
        name_len = 0;
      end
    end else begin
      res.push_back(decode_name());
      in_name  = 1'b0;
      name_len = 0;
      if (b != CH_SEMI) begin
        if (b == CH_AMP) in_name = 1'b1;
        else res.push_back(b);
      end
    end
    if (eot && in_name) begin
      res.push_back(decode_name());
      in_name  = 1'b0;
      name_len = 0;
    end
  endfunction

  // Drives one transaction and waits for its acceptance. The predictor runs
  // on acceptance so that the owed queue is always filled ahead of the result.
  // Valid drops only while idling, so back-to-back transactions keep it high.
  task automatic send_byte(logic [7:0] b, logic eot, logic has_want, logic [7:0] want);
    logic [7:0] res[$];
    while (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    decode_byte(b, eot, res);
    if (has_want && !(res.size() == 1 && res[0] == want)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row %02h: predictor gives %0d results, typed value %02h",
                 b, res.size(), want);
    end
    foreach (res[i]) owed_q.push_back('{data: res[i], last: (i == res.size() - 1)});
  endtask

  task automatic send_name(string s, logic [7:0] term, logic eot);
    send_byte(CH_AMP, 1'b0, 1'b0, 8'h00);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0, 1'b0, 8'h00);
    send_byte(term, eot, 1'b0, 8'h00);
  endtask

  // The result side: random back-pressure, checking each transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: byte %02h last %b", out_byte, out_run_last);
        end else begin
          if (out_byte !== owed_q[0].data || out_run_last !== owed_q[0].last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %02h/%b, got %02h/%b",
                       owed_q[0].data, owed_q[0].last, out_byte, out_run_last);
          end
          void'(owed_q.pop_front());
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 16);
    end
  end

  // Watchdog: cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("tb_sgml_entity_decoder: done, errors");
      $finish;
    end
  end

  // Directed table: single-result rows carry their value, others use the predictor.
  stim_row_t directed [] = '{
    '{8'h00, 1'b0, 1'b1, 8'h00},     // smallest plain byte
    '{8'hFF, 1'b0, 1'b1, 8'hFF},     // largest plain byte
    '{8'h3B, 1'b0, 1'b1, 8'h3B},     // semicolon outside an entity
    '{CH_AMP, 1'b0, 1'b0, 8'h00},    // empty name closed by a semicolon
    '{CH_SEMI, 1'b0, 1'b1, CH_SPACE},
    '{CH_AMP, 1'b1, 1'b1, CH_SPACE}, // entity opened by the final byte
    '{CH_AMP, 1'b0, 1'b0, 8'h00},    // ampersand closing an empty name
    '{CH_AMP, 1'b0, 1'b0, 8'h00},
    '{"l", 1'b0, 1'b0, 8'h00},
    '{"t", 1'b0, 1'b0, 8'h00},
    '{CH_SEMI, 1'b0, 1'b1, 8'd60},   // "lt"
    '{CH_AMP, 1'b0, 1'b0, 8'h00},
    '{"z", 1'b0, 1'b0, 8'h00},
    '{CH_SEMI, 1'b0, 1'b1, CH_SPACE},// unknown name
    '{"a", 1'b1, 1'b1, 8'h61}
  };

  initial begin
    logic [7:0] b;
    int         pick;
    int         len;
    string      s;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_text_byte   = 8'h00;
    in_end_of_text = 1'b0;
    out_ready      = 1'b0;
    in_name        = 1'b0;
    name_len       = 0;
    mismatches     = 0;
    idle_cycles    = 0;
    calm           = 1'b0;
    timed_out      = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_byte(directed[i].data, directed[i].eot, directed[i].has_want, directed[i].want);

    // Names covering the special cases: the Igrave and Iacute codes, the longest names,
    // non-semicolon terminators, flushes and overlong names.
    send_name("Igrave", CH_SEMI, 1'b0);
    send_name("Iacute", ",", 1'b0);
    send_name("yuml", CH_AMP, 1'b0);
    send_name("AElig", "x", 1'b1);
    send_name("frac34", CH_SEMI, 1'b0);
    send_name("LT", CH_SEMI, 1'b0);          // case matters
    send_name("a.b-c", CH_SEMI, 1'b0);
    send_name("abcdefghi", "j", 1'b0);       // tenth name byte aborts
    send_name("ZZZZZZZZZ", CH_SEMI, 1'b0);
    send_byte(CH_AMP, 1'b0, 1'b0, 8'h00);
    send_byte("g", 1'b0, 1'b0, 8'h00);
    send_byte("t", 1'b1, 1'b0, 8'h00);       // flushed by end of text

    // Hold the sender until everything owed has arrived.
    in_valid <= 1'b0;
    wait (owed_q.size() == 0);

    // Random part: mostly well-formed entities with random neighbours.
    for (int n = 0; n < RANDOM_ITEMS; ) begin
      calm = (n >= 40 && n < 90);
      pick = $urandom_range(99);
      if (pick < 45) begin
        s = ent_names[$urandom_range(TABLE_ENTRIES - 1)];
        b = ($urandom_range(3) == 0) ? 8'($urandom) : CH_SEMI;
        send_name(s, b, $urandom_range(9) == 0);
        n += s.len() + 2;
      end else if (pick < 60) begin
        // Random name bytes, sometimes beyond the length limit.
        len = $urandom_range(NAME_LIMIT + 1);
        send_byte(CH_AMP, 1'b0, 1'b0, 8'h00);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(3))
            0: b = 8'($urandom_range("A", "Z"));
            1: b = 8'($urandom_range("a", "z"));
            2: b = CH_DOT;
            default: b = CH_DASH;
          endcase
          send_byte(b, ($urandom_range(19) == 0), 1'b0, 8'h00);
        end
        n += len + 1;
      end else begin
        send_byte(8'($urandom), 1'($urandom_range(1)), 1'b0, 8'h00);
        n++;
      end
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    wait (owed_q.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && owed_q.size() == 0) begin
      $display("tb_sgml_entity_decoder: done, clean");
    end else begin
      $display("tb_sgml_entity_decoder: done, errors");
    end
    $finish;
  end
endmodule
